[rtl/core/sat_pkg.sv]
// Shared types and constants for the sensor average ASCII telemetry block.
// No dependencies.
package sat_pkg;

    localparam int SumW   = 13;
    localparam int CountW = 5;
    localparam int ChanW  = 3;
    localparam int SwW    = 6;
    localparam int QDepth = 2;

    localparam logic [ChanW-1:0] PrefixChan = 3'd0;
    localparam logic [ChanW-1:0] SpaceChan  = 3'd6;
    localparam logic [ChanW-1:0] LastChan   = 3'd7;

    localparam logic [7:0] ChrM     = 8'h6d;
    localparam logic [7:0] ChrY     = 8'h79;
    localparam logic [7:0] ChrN     = 8'h6e;
    localparam logic [7:0] ChrG     = 8'h67;
    localparam logic [7:0] ChrColon = 8'h3a;
    localparam logic [7:0] ChrSpace = 8'h20;
    localparam logic [7:0] ChrCr    = 8'h0d;
    localparam logic [7:0] ChrZero  = 8'h30;

    // byte positions within one channel's run
    localparam logic [3:0] StepM   = 4'd0;
    localparam logic [3:0] StepY   = 4'd1;
    localparam logic [3:0] StepN   = 4'd2;
    localparam logic [3:0] StepG   = 4'd3;
    localparam logic [3:0] StepPc  = 4'd4;
    localparam logic [3:0] StepD2  = 4'd5;
    localparam logic [3:0] StepD1  = 4'd6;
    localparam logic [3:0] StepD0  = 4'd7;
    localparam logic [3:0] StepSep = 4'd8;
    localparam logic [3:0] StepSw  = 4'd9;
    localparam logic [3:0] StepCr  = 4'd10;

    typedef struct packed {
        logic [7:0]     adc_sample;
        logic [SwW-1:0] switch_bits;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_beat;

    typedef struct packed {
        logic [SumW-1:0]  sum;
        logic [ChanW-1:0] chan;
        logic [SwW-1:0]   sw;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_EMIT
    } t_back_state;

endpackage

[rtl/core/sat_in_if.sv]
// Input beat channel: valid/ready handshake carrying one sample beat.
// Depends on sat_pkg.
interface sat_in_if;
    logic              valid;
    logic              ready;
    sat_pkg::t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/sat_out_if.sv]
// Output beat channel: valid/ready handshake carrying one telemetry byte.
// Depends on sat_pkg.
interface sat_out_if;
    logic               valid;
    logic               ready;
    sat_pkg::t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/sat_front.sv]
// Front end: accepts samples, keeps the running sum and counters,
// pushes a job per completed channel. Depends on sat_pkg.
module sat_front #(
    parameter int SAMPLES_PER_CHANNEL = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sat_pkg::t_in_beat i_beat,
    output logic              o_ready,
    input  sat_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output sat_pkg::t_job     o_job
);
    localparam logic [sat_pkg::CountW:0] Limit = (sat_pkg::CountW + 1)'(SAMPLES_PER_CHANNEL);

    logic [sat_pkg::CountW-1:0] r_count, n_count;
    logic [sat_pkg::ChanW-1:0]  r_chan;
    logic [sat_pkg::SumW-1:0]   r_sum, n_sum;
    logic                       w_done;
    logic                       w_acc;

    assign n_count = r_count + 1'b1;
    assign n_sum   = r_sum + sat_pkg::SumW'(i_beat.adc_sample);
    assign w_done  = (n_count == '0) || ({1'b0, n_count} >= Limit);
    assign o_ready = !(w_done && i_q_stat.full);
    assign w_acc   = i_valid && o_ready;
    assign o_push  = w_acc && w_done;

    assign o_job.sum  = n_sum;
    assign o_job.chan = r_chan;
    assign o_job.sw   = i_beat.switch_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_chan  <= '0;
            r_sum   <= '0;
        end else if (w_acc) begin
            if (w_done) begin
                r_count <= '0;
                r_sum   <= '0;
                r_chan  <= r_chan + 1'b1;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

endmodule

[rtl/core/sat_queue.sv]
// Short job queue between the front and back ends.
// Depends on sat_pkg.
module sat_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sat_pkg::t_job    i_job,
    input  logic             i_pop,
    output sat_pkg::t_job    o_job,
    output sat_pkg::t_q_stat o_stat
);
    localparam int PtrW = $clog2(sat_pkg::QDepth);

    sat_pkg::t_job            r_mem [sat_pkg::QDepth];
    logic [PtrW-1:0]          r_wr_ptr, r_rd_ptr;
    logic [PtrW:0]            r_fill;
    logic                     w_wr, w_rd;

    assign o_stat.valid = (r_fill != '0);
    assign o_stat.full  = (r_fill == (PtrW + 1)'(sat_pkg::QDepth));
    assign w_wr         = i_push && !o_stat.full;
    assign w_rd         = i_pop && o_stat.valid;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

[rtl/core/sat_back.sv]
// Back end: divides a channel sum by reciprocal multiply, splits the average
// into decimal digits and sequences the frame bytes. Depends on sat_pkg.
module sat_back #(
    parameter int SAMPLES_PER_CHANNEL = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sat_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output sat_pkg::t_out_beat o_beat
);
    localparam int ShiftW = sat_pkg::SumW + $clog2(SAMPLES_PER_CHANNEL);
    localparam int Recip  = ((1 << ShiftW) + SAMPLES_PER_CHANNEL - 1) / SAMPLES_PER_CHANNEL;
    localparam int RecipW = 15;
    localparam int ProdW  = sat_pkg::SumW + RecipW;

    sat_pkg::t_back_state        r_state, n_state;
    logic [ProdW-1:0]            r_prod;
    logic [sat_pkg::ChanW-1:0]   r_chan;
    logic [sat_pkg::SwW-1:0]     r_sw;
    logic [3:0]                  r_d2, r_d1, r_d0;
    logic [3:0]                  r_step;
    logic                        r_out_valid;
    sat_pkg::t_out_beat          r_out;

    logic [sat_pkg::SumW-1:0]    w_quot;
    logic [7:0]                  w_avg;
    logic [1:0]                  w_h;
    logic [6:0]                  w_rem;
    logic [3:0]                  w_t;
    logic [3:0]                  w_o;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_last;
    logic [7:0]                  w_byte;

    assign w_quot = sat_pkg::SumW'(r_prod >> ShiftW);
    assign w_avg  = (w_quot > sat_pkg::SumW'(255)) ? 8'd255 : w_quot[7:0];

    always_comb begin
        if (w_avg >= 8'd200) begin
            w_h = 2'd2;
        end else if (w_avg >= 8'd100) begin
            w_h = 2'd1;
        end else begin
            w_h = 2'd0;
        end
        w_rem = 7'(w_avg - 8'(w_h) * 8'd100);
        w_t   = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (w_rem >= 7'(10 * k)) begin
                w_t = 4'(k);
            end
        end
        w_o = 4'(w_rem - 7'(w_t) * 7'd10);
    end

    assign w_out_free = !r_out_valid || i_ready;
    assign w_last     = (r_step == sat_pkg::StepCr)
                     || (r_step == sat_pkg::StepSep && r_chan != sat_pkg::LastChan);

    always_comb begin
        unique case (r_step)
            sat_pkg::StepM:   w_byte = sat_pkg::ChrM;
            sat_pkg::StepY:   w_byte = sat_pkg::ChrY;
            sat_pkg::StepN:   w_byte = sat_pkg::ChrN;
            sat_pkg::StepG:   w_byte = sat_pkg::ChrG;
            sat_pkg::StepPc:  w_byte = sat_pkg::ChrColon;
            sat_pkg::StepD2:  w_byte = sat_pkg::ChrZero + 8'(r_d2);
            sat_pkg::StepD1:  w_byte = sat_pkg::ChrZero + 8'(r_d1);
            sat_pkg::StepD0:  w_byte = sat_pkg::ChrZero + 8'(r_d0);
            sat_pkg::StepSep: w_byte = (r_chan == sat_pkg::SpaceChan) ? sat_pkg::ChrSpace
                                                                     : sat_pkg::ChrColon;
            sat_pkg::StepSw:  w_byte = 8'(r_sw);
            sat_pkg::StepCr:  w_byte = sat_pkg::ChrCr;
            default:          w_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sat_pkg::BK_IDLE: if (i_q_valid) n_state = sat_pkg::BK_MUL;
            sat_pkg::BK_MUL:  n_state = sat_pkg::BK_EMIT;
            sat_pkg::BK_EMIT: if (w_out_free && w_last) n_state = sat_pkg::BK_IDLE;
            default:          n_state = sat_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == sat_pkg::BK_IDLE) && i_q_valid;
        w_emit = (r_state == sat_pkg::BK_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sat_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod <= ProdW'(i_job.sum) * ProdW'(RecipW'(Recip));
            r_chan <= i_job.chan;
            r_sw   <= i_job.sw;
        end
        if (r_state == sat_pkg::BK_MUL) begin
            r_d2   <= 4'(w_h);
            r_d1   <= w_t;
            r_d0   <= w_o;
            r_step <= (r_chan == sat_pkg::PrefixChan) ? sat_pkg::StepM : sat_pkg::StepD2;
        end else if (w_emit) begin
            r_step <= r_step + 1'b1;
        end
        if (w_emit) begin
            r_out.out_byte    <= w_byte;
            r_out.last_of_run <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

[rtl/core/sensor_average_ascii_telemetry.sv]
// Top level of the sensor average ASCII telemetry block.
// Depends on sat_pkg, sat_in_if, sat_out_if, sat_front, sat_queue, sat_back.
//
// Samples arrive channel by channel, SAMPLES_PER_CHANNEL per channel for eight
// channels; the front end takes one sample every cycle and only stalls when a
// channel completes while the two-entry job queue is full. Each completed
// channel becomes a run of 4 to 9 bytes ("myng:" before channel 0, three
// average digits, a separator, then switch byte and CR after channel 7); the
// back end first registers the reciprocal multiply product, then the digit
// split, and then emits one byte per cycle through a registered output,
// stalling while the output is not ready.
module sensor_average_ascii_telemetry #(
    parameter int SAMPLES_PER_CHANNEL = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sat_in_if.sink         i_in,
    sat_out_if.source      o_out
);
    logic             w_push;
    logic             w_pop;
    sat_pkg::t_job    w_front_job;
    sat_pkg::t_job    w_back_job;
    sat_pkg::t_q_stat w_q_stat;

    sat_front #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_beat   (i_in.data),
        .o_ready  (i_in.ready),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_front_job)
    );

    sat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_job   (w_back_job),
        .o_stat  (w_q_stat)
    );

    sat_back #(
        .SAMPLES_PER_CHANNEL(SAMPLES_PER_CHANNEL)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_stat.valid),
        .i_job     (w_back_job),
        .o_pop     (w_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_beat    (o_out.data)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("channel job pushed into a full queue");

    a_run_ends_on_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.last_of_run) |->
            (o_out.data.out_byte == sat_pkg::ChrColon
             || o_out.data.out_byte == sat_pkg::ChrSpace
             || o_out.data.out_byte == sat_pkg::ChrCr))
        else $error("byte run ends on an unexpected byte");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_stat.valid)
        else $error("back end popped an empty queue");
`endif

endmodule
